>>> rtl/core/lfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg - letter frequency rank shared definitions
// Character codes, field widths, default sizes and the scan control type.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int CHAR_BITS = 8;
    localparam int OCC_BITS  = 16;

    localparam logic [CHAR_BITS-1:0] FIRST_LETTER = 8'd97;   // 'a'
    localparam logic [CHAR_BITS-1:0] END_BYTE     = 8'd122;  // 'z'

    localparam int DEF_NUM_LETTERS = 25;
    localparam int DEF_COUNT_BITS  = 16;

    // controls for the shared compare unit
    typedef struct packed {
        logic clear;  // forget the current best before a new scan
        logic step;   // offer one counter to the compare
    } t_scan_ctl;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

endpackage : lfr_pkg
`default_nettype wire

>>> rtl/core/lfr_argmax.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_argmax - shared compare unit of the ranking pass
// Takes one counter per step and keeps the largest nonzero one; the earliest
// index wins a tie. Also flags whether more than one candidate was seen.
// ----------------------------------------------------------------------------
module lfr_argmax #(
    parameter int COUNT_BITS = lfr_pkg::DEF_COUNT_BITS,
    parameter int IDX_W      = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire lfr_pkg::t_scan_ctl i_ctl,
    input  wire [IDX_W-1:0]       i_idx,
    input  wire [COUNT_BITS-1:0]  i_count,
    input  wire                   i_eligible,
    output logic                  o_found,
    output logic                  o_multi,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [COUNT_BITS-1:0] o_best_count
);
    import lfr_pkg::*;

    logic                  r_found, n_found;
    logic                  r_multi, n_multi;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [COUNT_BITS-1:0] r_best_count, n_best_count;
    logic                  candidate;

    assign candidate = i_eligible && (i_count != '0);

    always_comb begin
        n_found      = r_found;
        n_multi      = r_multi;
        n_best_idx   = r_best_idx;
        n_best_count = r_best_count;
        if (i_ctl.clear) begin
            n_found      = 1'b0;
            n_multi      = 1'b0;
            n_best_count = '0;
        end else if (i_ctl.step && candidate) begin
            n_found = 1'b1;
            if (r_found) begin
                n_multi = 1'b1;
            end
            // strict compare keeps the alphabetically first on a tie
            if (i_count > r_best_count) begin
                n_best_count = i_count;
                n_best_idx   = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_multi      <= 1'b0;
            r_best_count <= '0;
        end else begin
            r_found      <= n_found;
            r_multi      <= n_multi;
            r_best_count <= n_best_count;
        end
        r_best_idx <= n_best_idx;
    end

    assign o_found      = r_found;
    assign o_multi      = r_multi;
    assign o_best_idx   = r_best_idx;
    assign o_best_count = r_best_count;

endmodule : lfr_argmax
`default_nettype wire

>>> rtl/core/letter_frequency_rank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// letter_frequency_rank - histogram of word-initial letters, ranked output
// Counts lower-case initials and, on 'z', reports them by descending count.
// ----------------------------------------------------------------------------
// Each input transfer is one byte. A letter from 'a' upwards (NUM_LETTERS of
// them) bumps its saturating counter, and any other byte except 'z' is
// dropped, so the load runs at one byte per clock while idle. A 'z' starts
// the ranking pass, during which the input is not ready: one shared compare
// unit walks the counters one per cycle, so each reported letter takes a scan
// of all NUM_LETTERS counters, then the decision state, then a wait in the
// output register until the sink takes it. An empty histogram gives one
// result flagged empty. Equal counts come out alphabetically, the final
// result carries last, and all counters are cleared when that final result
// transfers.
// ----------------------------------------------------------------------------
module letter_frequency_rank #(
    parameter int NUM_LETTERS = lfr_pkg::DEF_NUM_LETTERS,
    parameter int COUNT_BITS  = lfr_pkg::DEF_COUNT_BITS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // byte input channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [lfr_pkg::CHAR_BITS-1:0]   i_first_char,
    // ranked result channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [lfr_pkg::CHAR_BITS-1:0]  o_letter,
    output logic [lfr_pkg::OCC_BITS-1:0]   o_occurrences,
    output logic                           o_last,
    output logic                           o_empty_res
);
    import lfr_pkg::*;

    localparam int IDX_W = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LETTERS - 1);

    // state
    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_counts [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] r_emitted;
    logic [IDX_W-1:0]      r_idx, n_idx;

    // output register
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_letter;
    logic [OCC_BITS-1:0]   r_occ;
    logic                  r_last;
    logic                  r_empty;

    // input decode
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  is_end;
    logic [CHAR_BITS-1:0]  char_off;
    logic                  is_letter;
    logic [IDX_W-1:0]      in_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  bump;

    // compare unit
    t_scan_ctl             scan_ctl;
    logic                  best_found;
    logic                  best_multi;
    logic [IDX_W-1:0]      best_idx;
    logic [COUNT_BITS-1:0] best_count;
    logic [OCC_BITS-1:0]   occ_sat;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    assign is_end    = (i_first_char == END_BYTE);
    assign char_off  = i_first_char - FIRST_LETTER;
    assign is_letter = (i_first_char >= FIRST_LETTER) &&
                       ({1'b0, char_off} < 9'(NUM_LETTERS));
    assign in_idx    = char_off[IDX_W-1:0];

    // one read port: the input letter while loading, the scan pointer otherwise
    assign rd_idx   = (r_state == S_IDLE) ? in_idx : r_idx;
    assign rd_count = r_counts[rd_idx];
    assign bump     = in_xfer && !is_end && is_letter && (rd_count != '1);

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        scan_ctl.clear = 1'b0;
        scan_ctl.step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && is_end) begin
                    scan_ctl.clear = 1'b1;
                    n_idx          = '0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                scan_ctl.step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_xfer) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        scan_ctl.clear = 1'b1;
                        n_idx          = '0;
                        n_state        = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    lfr_argmax #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_argmax (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (r_idx),
        .i_count      (rd_count),
        .i_eligible   (!r_emitted[r_idx]),
        .o_found      (best_found),
        .o_multi      (best_multi),
        .o_best_idx   (best_idx),
        .o_best_count (best_count)
    );

    // clip wide counters to the 16-bit result field
    generate
        if (COUNT_BITS > OCC_BITS) begin : g_clip
            assign occ_sat = (|best_count[COUNT_BITS-1:OCC_BITS]) ? '1 :
                             best_count[OCC_BITS-1:0];
        end else begin : g_ext
            assign occ_sat = OCC_BITS'(best_count);
        end
    endgenerate

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_emitted   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_state == S_DECIDE) begin
                r_out_valid <= 1'b1;
                if (best_found) begin
                    r_emitted[best_idx] <= 1'b1;
                end
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
                if (r_last) begin
                    r_emitted <= '0;
                end
            end
        end
    end

    // counter bank: bumped while loading, cleared after the final transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (out_xfer && r_last)) begin
            for (int k = 0; k < NUM_LETTERS; k++) begin
                r_counts[k] <= '0;
            end
        end else if (bump) begin
            r_counts[in_idx] <= rd_count + 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            if (best_found) begin
                r_letter <= FIRST_LETTER + CHAR_BITS'(best_idx);
                r_occ    <= occ_sat;
                r_last   <= !best_multi;
                r_empty  <= 1'b0;
            end else begin
                // nothing counted at all
                r_letter <= '0;
                r_occ    <= '0;
                r_last   <= 1'b1;
                r_empty  <= 1'b1;
            end
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_letter      = r_letter;
    assign o_occurrences = r_occ;
    assign o_last        = r_last;
    assign o_empty_res   = r_empty;

    // checks
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_last && (o_occurrences == '0))
        else $error("empty result without last or with a count");

    a_nonempty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_empty_res |-> o_occurrences != '0)
        else $error("ranked letter reported with zero count");

    a_no_load_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_out_valid)
        else $error("result register busy during a scan");

    a_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_last |=> (r_emitted == '0) && o_in_ready)
        else $error("pass did not return to loading cleanly");

endmodule : letter_frequency_rank
`default_nettype wire
